FILE: hw/rtl/md5d_pkg.sv
// ---------------------------------------------------------------------------
// md5d_pkg
// Shared constants, types and round tables for the MD5 digest block.
// ---------------------------------------------------------------------------
`default_nettype none
package md5d_pkg;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;
    localparam logic [5:0]  POS_LAST   = 6'h3f;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    typedef enum logic [0:0] {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    // Request travelling from front to back through the queue
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_req;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] r;
        begin
            case ({i[5:4], i[1:0]})
                4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
                4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
                4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
                4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    // Message word index for each round
    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0: g = i[3:0];
                2'd1: g = 4'((5 * i[3:0]) + 1);
                2'd2: g = 4'((3 * i[3:0]) + 5);
                default: g = 4'(7 * i[3:0]);
            endcase
            return g;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/md5d_front.sv
// ---------------------------------------------------------------------------
// md5d_front
// Input request queue: takes requests, holds them until the core is free.
// ---------------------------------------------------------------------------
`default_nettype none
module md5d_front
    import md5d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_req      o_req
);
    localparam int AW = $clog2(DEPTH);

    t_req            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/md5d_core.sv
// ---------------------------------------------------------------------------
// md5d_core
// Byte buffer, padding sequencer, one-round-per-cycle compression, output.
// ---------------------------------------------------------------------------
`default_nettype none
module md5d_core
    import md5d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_req        i_req,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_word,
    output logic [1:0]       o_index,
    output logic             o_last
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    logic [31:0]  r_msg [16];
    logic [31:0]  r_h [4];
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [63:0]  r_bits, r_len;
    logic [5:0]   r_round;
    logic         r_fin;     // compression belongs to the finish sequence
    logic         r_pad_done; // length bytes written, digest ready after fold
    logic         r_tail_zero; // pad byte sat at 56..63: zero this tail, length next block
    logic [1:0]   r_oidx;
    logic         w_wr;
    logic [7:0]   w_byte;
    logic [5:0]   w_pos;
    logic [31:0]  w_f, w_sum, w_rot;

    assign w_pos   = r_bits[8:3];
    assign o_ready = (r_state == S_IDLE);

    // Byte to write this cycle: a data request, or a generated pad/length byte
    always_comb begin
        w_wr   = 1'b0;
        w_byte = 8'h00;
        if (r_state == S_IDLE && i_valid && i_req.cmd == CMD_ABSORB) begin
            w_wr   = 1'b1;
            w_byte = i_req.data;
        end else if (r_state == S_IDLE && i_valid) begin
            w_wr   = 1'b1;
            w_byte = PAD_BYTE;
        end else if (r_state == S_PAD) begin
            w_wr = 1'b1;
            if (w_pos >= LEN_OFFSET && !r_tail_zero) begin
                w_byte = r_len[8*(w_pos[2:0]) +: 8];
            end
        end
    end

    always_comb begin
        case (r_round[5:4])
            2'd0: w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1: w_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
        w_sum = r_a + w_f + sine_k(r_round) + r_msg[msg_idx(r_round)];
        w_rot = (w_sum << rot_amt(r_round)) | (w_sum >> (6'd32 - {1'b0, rot_amt(r_round)}));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = (w_pos == POS_LAST) ? S_LOAD
                                     : (i_req.cmd == CMD_FINISH) ? S_PAD : S_IDLE;
            end
            S_PAD:   if (w_pos == POS_LAST) n_state = S_LOAD;
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: if (r_round == 6'd63) n_state = S_FOLD;
            S_FOLD:  n_state = !r_fin ? S_IDLE : r_pad_done ? S_OUT : S_PAD;
            S_OUT:   if (i_ready && r_oidx == 2'd3) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_msg[w_pos[5:2]][8*w_pos[1:0] +: 8] <= w_byte;
        if (r_state == S_IDLE && i_valid && i_req.cmd == CMD_FINISH) r_len <= r_bits;
        if (r_state == S_LOAD) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
        end else if (r_state == S_ROUND) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= r_b + w_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bits      <= '0;
            r_round     <= '0;
            r_fin       <= 1'b0;
            r_pad_done  <= 1'b0;
            r_tail_zero <= 1'b0;
            r_oidx      <= '0;
            r_h[0] <= INIT_A; r_h[1] <= INIT_B; r_h[2] <= INIT_C; r_h[3] <= INIT_D;
        end else begin
            r_state <= n_state;
            if (w_wr) r_bits <= r_bits + 64'd8;
            if (r_state == S_IDLE && i_valid) begin
                r_fin       <= (i_req.cmd == CMD_FINISH);
                r_pad_done  <= 1'b0;
                r_tail_zero <= (i_req.cmd == CMD_FINISH) && (w_pos >= LEN_OFFSET);
            end
            if (r_state == S_PAD && w_pos == POS_LAST && !r_tail_zero) r_pad_done <= 1'b1;
            if (r_state == S_ROUND) r_round <= r_round + 6'd1;
            if (r_state == S_FOLD) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_oidx <= '0;
                r_tail_zero <= 1'b0;
            end
            if (r_state == S_OUT && i_ready) begin
                r_oidx <= r_oidx + 2'd1;
                if (r_oidx == 2'd3) begin
                    r_h[0] <= INIT_A; r_h[1] <= INIT_B;
                    r_h[2] <= INIT_C; r_h[3] <= INIT_D;
                    r_bits <= '0;
                end
            end
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_word  = r_h[r_oidx];
    assign o_index = r_oidx;
    assign o_last  = (r_oidx == 2'd3);
endmodule
`default_nettype wire

FILE: hw/rtl/md5_digest.sv
// ---------------------------------------------------------------------------
// md5_digest
// MD5 message digest over a byte stream.
// ---------------------------------------------------------------------------
// Each absorb request adds one byte; the 64th byte of a block starts a
// compression (load, 64 rounds through one shared round unit, fold),
// during which requests collect in a small queue. A finish request
// writes the padding and length at one byte per cycle, held while a
// compression runs (up to 72 bytes, so one or two compressions), and then
// returns words A, B, C, D, the last flagged. After an absorb that fills no
// block, the core stays idle and can take the next byte straight away.
`default_nettype none
module md5_digest
    import md5d_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [1:0]       o_word_index,
    output logic             o_last_word
);
    t_req w_in_req, w_q_req;
    logic w_q_valid, w_q_ready;

    assign w_in_req.cmd  = t_cmd'(i_cmd);
    assign w_in_req.data = i_data_byte;

    md5d_front #(.DEPTH(QDEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(w_in_req),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_req(w_q_req)
    );

    md5d_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_req(w_q_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_digest_word),
        .o_index(o_word_index), .o_last(o_last_word)
    );

`ifndef SYNTH
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 2'd3)))
        else $error("last flag mismatch");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_word) |=> (o_valid &&
        o_word_index == $past(o_word_index) + 2'd1))
        else $error("digest word sequence broken");
`endif
endmodule
`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for md5_digest: byte messages in, digest words out.
// ---------------------------------------------------------------------------
// Each accepted request goes into a digest model held by the scoreboard.
// An absorb request adds one byte. A finish request pads the message,
// compresses, and queues the four expected words. Each word that the block
// returns is checked against the oldest one waiting.
`default_nettype none

class md5_scoreboard;
    logic [31:0] chain[4];
    logic [7:0]  blk[64];
    logic [63:0] nbits;
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } t_word;
    t_word       pending[$];
    int          errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        chain[0] = md5d_pkg::INIT_A;
        chain[1] = md5d_pkg::INIT_B;
        chain[2] = md5d_pkg::INIT_C;
        chain[3] = md5d_pkg::INIT_D;
        nbits = '0;
    endfunction

    // Round constants: floor(abs(sin(i+1)) * 2^32)
    function logic [31:0] kval(int i);
        logic [31:0] kt[64];
        kt = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
               32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
               32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
               32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
               32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
               32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
               32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
               32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
               32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
               32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
               32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
               32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
               32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
               32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
               32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
               32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return kt[i];
    endfunction

    function void fold_block();
        logic [31:0] m[16];
        logic [31:0] a, b, c, d, f, t, s;
        int          g, r, sh;
        int          shifts[16];
        shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            r = i / 16;
            case (r)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
                2: begin f = b ^ c ^ d;          g = (3*i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
            endcase
            sh = shifts[r*4 + i%4];
            s = a + f + kval(i) + m[g];
            t = d; d = c; c = b;
            b = b + ((s << sh) | (s >> (32 - sh)));
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function void add_byte(logic [7:0] v);
        logic [5:0] pos;
        pos = nbits[8:3];
        blk[pos] = v;
        nbits += 64'd8;
        if (pos == md5d_pkg::POS_LAST) fold_block();
    endfunction

    // Note one accepted request
    function void note_request(md5d_pkg::t_cmd cmd, logic [7:0] data);
        logic [63:0] len;
        t_word       w;
        if (cmd == md5d_pkg::CMD_ABSORB) begin
            add_byte(data);
            return;
        end
        len = nbits;
        add_byte(md5d_pkg::PAD_BYTE);
        while (nbits[8:3] != md5d_pkg::LEN_OFFSET) add_byte(8'h00);
        for (int k = 0; k < 8; k++) add_byte(len[8*k +: 8]);
        for (int k = 0; k < 4; k++) begin
            w.word = chain[k];
            w.idx  = 2'(k);
            w.last = (k == 3);
            pending.push_back(w);
        end
        restart();
    endfunction

    // Check one returned digest word
    function void check_word(logic [31:0] word, logic [1:0] idx, logic last);
        t_word e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected word %h idx %0d last %0d", word, idx, last);
            return;
        end
        e = pending.pop_front();
        if (e.word !== word || e.idx !== idx || e.last !== last) begin
            errors++;
            if (errors <= 10)
                $display("word mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                         e.word, e.idx, e.last, word, idx, last);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import md5d_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic        req_cmd = 1'b0;
    logic [7:0]  req_data = '0;
    logic        word_valid;
    logic        word_ready = 1'b0;
    logic [31:0] word_data;
    logic [1:0]  word_idx;
    logic        word_last;
    int          cycles = 0;
    int          stall_mode = 0;

    md5_scoreboard sb = new();

    md5_digest u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_cmd         (req_cmd),
        .i_data_byte   (req_data),
        .o_valid       (word_valid),
        .i_ready       (word_ready),
        .o_digest_word (word_data),
        .o_word_index  (word_idx),
        .o_last_word   (word_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Scoreboard hooks at the rising edge
    always @(posedge clk) begin
        if (rst_n && req_valid && req_ready)
            sb.note_request(t_cmd'(req_cmd), req_data);
        if (rst_n && word_valid && word_ready)
            sb.check_word(word_data, word_idx, word_last);
    end

    // Receiver: stall pattern switches between free-running, light and heavy
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: word_ready <= 1'b1;
            1: word_ready <= ($urandom_range(0, 3) != 0);
            default: word_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Send one request; valid stays high until accepted. Lowering is left to
    // the caller so back-to-back requests keep valid high without a glitch.
    task automatic send_req(t_cmd cmd, logic [7:0] data);
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_data  <= data;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    task automatic gap();
        int n;
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_message(int len, bit burst);
        for (int i = 0; i < len; i++) begin
            send_req(CMD_ABSORB, 8'($urandom_range(0, 255)));
            if (burst) gap();
        end
        send_req(CMD_FINISH, 8'($urandom_range(0, 255)));
        if (burst) gap();
    endtask

    int lens[$];

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty message, finish with stray data, extreme bytes
        send_req(CMD_FINISH, 8'h00);
        send_req(CMD_FINISH, 8'hff);
        send_req(CMD_ABSORB, 8'h00);
        send_req(CMD_ABSORB, 8'hff);
        send_req(CMD_ABSORB, 8'h80);
        send_req(CMD_ABSORB, 8'h7f);
        send_req(CMD_FINISH, 8'h55);
        req_valid <= 1'b0;

        // Lengths around the one/two-block padding boundary and a full block
        lens = '{55, 56, 63, 64};
        foreach (lens[i]) send_message(lens[i], 1'b1);

        // Random short messages with bursty gaps
        for (int m = 0; m < 4; m++)
            send_message($urandom_range(0, 4), 1'b1);
        req_valid <= 1'b0;

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: files.f
hw/rtl/md5d_pkg.sv
hw/rtl/md5d_front.sv
hw/rtl/md5d_core.sv
hw/rtl/md5_digest.sv
tb/tb.sv
